// ----- rtl/wavelet_analysis_step_top_macros.svh -----
// Assertion macros for the wavelet analysis checker.
`ifndef WAVELET_ANALYSIS_STEP_TOP_MACROS_SVH
`define WAVELET_ANALYSIS_STEP_TOP_MACROS_SVH

// Clocked assertion, ignored while reset is high.
`define WAS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define WAS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/was_pkg.sv -----
`timescale 1ns / 1ps
package was_pkg;

  localparam int TAPS       = 16;
  localparam int HEAD_LEN   = 15;
  localparam int TAP_BITS   = 23;
  localparam int MIN_HALF   = 16;
  localparam int CFG_BITS   = 11;
  localparam int INDEX_BITS = 10;

  typedef logic signed [TAP_BITS-1:0] tap_t;

  // Low-pass taps for offsets -7..8, Q1.22
  localparam tap_t LO_TAP [TAPS] = '{
    -23'sd14187, -23'sd2274, 23'sd132939, 23'sd31908,
    -23'sd601020, -23'sd256999, 23'sd2018969, 23'sd3259753,
    23'sd1528580, -23'sd217877, -23'sd114165, 23'sd206096,
    23'sd15975, -23'sd62714, -23'sd1271, 23'sd7927
  };

  // High-pass taps for offsets -7..8, Q1.22
  localparam tap_t HI_TAP [TAPS] = '{
    -23'sd7927, -23'sd1271, 23'sd62714, 23'sd15975,
    -23'sd206096, -23'sd114165, 23'sd217877, 23'sd1528580,
    -23'sd3259753, 23'sd2018969, 23'sd256999, -23'sd601020,
    -23'sd31908, 23'sd132939, 23'sd2274, -23'sd14187
  };

  typedef enum logic {
    FS_STREAM,
    FS_WRAP
  } front_state_t;

  typedef enum logic [0:0] {
    CFG_HALF_LENGTH = 1'b0,
    CFG_SHRINK_MODE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] index;
    logic                  last;
  } job_ctl_t;

endpackage

// ----- rtl/was_if.sv -----
`timescale 1ns / 1ps
// Sample channel
interface was_in_if #(parameter int SAMPLE_BITS = 32) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// Coefficient pair channel
interface was_out_if #(parameter int SAMPLE_BITS = 32) ();
  logic                              valid;
  logic                              ready;
  logic [was_pkg::INDEX_BITS-1:0]    coeff_index;
  logic signed [SAMPLE_BITS-1:0]     smooth;
  logic signed [SAMPLE_BITS-1:0]     detail;
  logic                              saturated;
  logic                              last_of_line;

  modport source (output valid, output coeff_index, output smooth, output detail,
                  output saturated, output last_of_line, input ready);
  modport sink (input valid, input coeff_index, input smooth, input detail,
                input saturated, input last_of_line, output ready);
endinterface

// ----- rtl/was_front.sv -----
`timescale 1ns / 1ps
module was_front #(
  parameter int MAX_HALF    = 1024,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        cfg_we,
  input  logic [0:0]                                  cfg_index,
  input  logic [was_pkg::CFG_BITS-1:0]                cfg_data,
  was_in_if.sink                                      samples,
  input  logic                                        q_ready,
  output logic                                        push,
  output logic [was_pkg::TAPS*SAMPLE_BITS-1:0]        job_data,
  output was_pkg::job_ctl_t                           job_ctl
);

  localparam int SB   = SAMPLE_BITS;
  localparam int NT   = was_pkg::TAPS;
  localparam int NH   = was_pkg::HEAD_LEN;
  localparam int CW   = $clog2(2 * MAX_HALF + 15);
  localparam int NW   = $clog2(MAX_HALF + 1);
  localparam int HW   = $clog2(NH);
  localparam int SNAP = 20;
  localparam int NE   = NT + NH;

  logic signed [SB-1:0] window   [NT];
  logic signed [SB-1:0] head     [NH];
  logic signed [SB-1:0] ext      [NE];
  logic signed [SB-1:0] win_new  [NT];
  logic signed [SB-1:0] snap     [SNAP];
  logic signed [SB-1:0] snap_next[SNAP];
  logic signed [SB-1:0] vec      [NT];

  logic [was_pkg::CFG_BITS-1:0] half_length;
  logic                         shrink_mode;
  logic [CW-1:0]                count;
  logic [NW-1:0]                n;
  logic [CW-1:0]                len;
  logic [CW-1:0]                one_index;
  logic [CW-1:0]                wrap_index;
  logic [2:0]                   r;
  logic                         is_last;
  logic                         emit_one;
  logic                         acc;

  was_pkg::front_state_t state, state_next;

  // Clamp the line length register
  always_comb begin
    if (half_length < was_pkg::CFG_BITS'(was_pkg::MIN_HALF)) begin
      n = NW'(was_pkg::MIN_HALF);
    end else if (32'(half_length) > MAX_HALF) begin
      n = NW'(MAX_HALF);
    end else begin
      n = NW'(half_length);
    end
  end

  assign len     = (CW'(n) << 1) + (shrink_mode ? CW'(14) : CW'(0));
  assign is_last = (count == len - CW'(1));
  assign acc     = samples.valid && samples.ready;

  // Classify the incoming sample
  assign emit_one = shrink_mode ? (count[0] && count >= CW'(15))
                                : (!count[0] && count >= CW'(16) && count <= len - CW'(2));
  assign one_index  = shrink_mode ? ((count >> 1) - CW'(7)) : ((count >> 1) - CW'(4));
  assign wrap_index = (r < 3'd4) ? CW'(r) : (CW'(n) - CW'(8) + CW'(r));

  // Window after the current sample, and the wrapped line: window then head
  always_comb begin
    for (int j = 0; j < NT; j++) begin
      win_new[j] = (j < NT - 1) ? window[(j + 1) % NT] : samples.sample;
    end
    for (int e = 0; e < NE; e++) begin
      ext[e] = (e < NT) ? window[e % NT] : head[(e + NH - NT) % NH];
    end
  end

  // Wrapped taps: reload at the first pair of each end, then step by two
  always_comb begin
    for (int k = 0; k < SNAP; k++) begin
      if (r == 3'd0) begin
        snap_next[k] = ext[11 + k];
      end else if (r == 3'd4) begin
        snap_next[k] = ext[3 + k];
      end else begin
        snap_next[k] = (k + 2 < SNAP) ? snap[(k + 2) % SNAP] : snap[k];
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      was_pkg::FS_STREAM: begin
        if (acc && !shrink_mode && is_last) state_next = was_pkg::FS_WRAP;
      end
      was_pkg::FS_WRAP: begin
        if (q_ready && r == 3'd7) state_next = was_pkg::FS_STREAM;
      end
      default: state_next = was_pkg::FS_STREAM;
    endcase
  end

  // Outputs
  always_comb begin
    samples.ready = 1'b0;
    push          = 1'b0;
    job_ctl.index = was_pkg::INDEX_BITS'(one_index);
    job_ctl.last  = 1'b0;
    for (int j = 0; j < NT; j++) vec[j] = win_new[j];
    unique case (state)
      was_pkg::FS_STREAM: begin
        samples.ready = q_ready;
        push          = acc && emit_one;
        job_ctl.last  = shrink_mode && is_last;
      end
      was_pkg::FS_WRAP: begin
        push          = q_ready;
        job_ctl.index = was_pkg::INDEX_BITS'(wrap_index);
        job_ctl.last  = (r == 3'd7);
        for (int j = 0; j < NT; j++) begin
          if (r == 3'd0) vec[j] = ext[9 + j];
          else if (r == 3'd4) vec[j] = ext[1 + j];
          else vec[j] = snap[j];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int j = 0; j < NT; j++) job_data[j*SB +: SB] = vec[j];
  end

  // Control state, window and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= was_pkg::FS_STREAM;
      r           <= 3'd0;
      count       <= '0;
      half_length <= was_pkg::CFG_BITS'(was_pkg::MIN_HALF);
      shrink_mode <= 1'b0;
      for (int j = 0; j < NT; j++) window[j] <= '0;
    end else begin
      state <= state_next;
      if (state == was_pkg::FS_STREAM) begin
        r <= 3'd0;
      end else if (q_ready) begin
        r <= r + 3'd1;
      end
      if (acc) begin
        for (int j = 0; j < NT; j++) window[j] <= win_new[j];
      end
      if (cfg_we) begin
        unique case (cfg_index)
          was_pkg::CFG_HALF_LENGTH: half_length <= cfg_data;
          was_pkg::CFG_SHRINK_MODE: shrink_mode <= cfg_data[0];
          default: ;
        endcase
        count <= '0;
      end else if (acc) begin
        count <= is_last ? '0 : count + CW'(1);
      end
    end
  end

  // Head of the line and wrapped taps
  always_ff @(posedge clk) begin
    if (acc && count < CW'(NH)) head[count[HW-1:0]] <= samples.sample;
    if (state == was_pkg::FS_WRAP && q_ready) begin
      for (int k = 0; k < SNAP; k++) snap[k] <= snap_next[k];
    end
  end

endmodule

// ----- rtl/was_queue.sv -----
`timescale 1ns / 1ps
module was_queue #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

  assign pop_data = mem[rd_ptr];

endmodule

// ----- rtl/was_back.sv -----
`timescale 1ns / 1ps
module was_back #(
  parameter int SAMPLE_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  q_valid,
  input  logic [was_pkg::TAPS*SAMPLE_BITS-1:0]  q_data,
  input  was_pkg::job_ctl_t                     q_ctl,
  output logic                                  q_pop,
  was_out_if.source                             results
);

  localparam int SB = SAMPLE_BITS;
  localparam int NT = was_pkg::TAPS;
  localparam int PW = SB + was_pkg::TAP_BITS;
  localparam int SW = PW + 4;
  localparam int QW = SW - 22;
  localparam logic signed [SW-1:0] ROUND = SW'(1) << 21;

  logic signed [SB-1:0] x       [NT];
  logic signed [PW-1:0] prod_lo [NT];
  logic signed [PW-1:0] prod_hi [NT];
  logic signed [SW-1:0] grp_lo  [4];
  logic signed [SW-1:0] grp_hi  [4];
  logic signed [SW-1:0] sum_lo;
  logic signed [SW-1:0] sum_hi;
  logic signed [QW-1:0] q_lo;
  logic signed [QW-1:0] q_hi;
  logic signed [SB-1:0] sat_lo;
  logic signed [SB-1:0] sat_hi;
  logic                 clip_lo;
  logic                 clip_hi;
  logic                 va, vb, vc, out_valid;
  logic                 en;

  was_pkg::job_ctl_t ctl_a, ctl_b, ctl_c;

  // Whole pipeline advances unless the output register is stuck
  assign en    = !out_valid || results.ready;
  assign q_pop = en && q_valid;

  always_comb begin
    for (int j = 0; j < NT; j++) x[j] = q_data[j*SB +: SB];
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va        <= q_valid;
      vb        <= va;
      vc        <= vb;
      out_valid <= vc;
    end
  end

  // Products
  always_ff @(posedge clk) begin
    if (en) begin
      ctl_a <= q_ctl;
      for (int j = 0; j < NT; j++) begin
        prod_lo[j] <= x[j] * was_pkg::LO_TAP[j];
        prod_hi[j] <= x[j] * was_pkg::HI_TAP[j];
      end
    end
  end

  // Partial sums of four
  always_ff @(posedge clk) begin
    if (en) begin
      ctl_b <= ctl_a;
      for (int g = 0; g < 4; g++) begin
        grp_lo[g] <= SW'(prod_lo[4*g]) + SW'(prod_lo[4*g+1])
                   + SW'(prod_lo[4*g+2]) + SW'(prod_lo[4*g+3]);
        grp_hi[g] <= SW'(prod_hi[4*g]) + SW'(prod_hi[4*g+1])
                   + SW'(prod_hi[4*g+2]) + SW'(prod_hi[4*g+3]);
      end
    end
  end

  // Final sum, round half up to 16 fraction bits
  assign sum_lo = grp_lo[0] + grp_lo[1] + grp_lo[2] + grp_lo[3] + ROUND;
  assign sum_hi = grp_hi[0] + grp_hi[1] + grp_hi[2] + grp_hi[3] + ROUND;

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_c <= ctl_b;
      q_lo  <= sum_lo[SW-1:22];
      q_hi  <= sum_hi[SW-1:22];
    end
  end

  // Saturate to the sample range
  always_comb begin
    clip_lo = !((&q_lo[QW-1:SB-1]) || !(|q_lo[QW-1:SB-1]));
    clip_hi = !((&q_hi[QW-1:SB-1]) || !(|q_hi[QW-1:SB-1]));
    sat_lo  = clip_lo ? (q_lo[QW-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}})
                      : q_lo[SB-1:0];
    sat_hi  = clip_hi ? (q_hi[QW-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}})
                      : q_hi[SB-1:0];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      results.coeff_index  <= ctl_c.index;
      results.last_of_line <= ctl_c.last;
      results.smooth       <= sat_lo;
      results.detail       <= sat_hi;
      results.saturated    <= clip_lo || clip_hi;
    end
  end

  assign results.valid = out_valid;

endmodule

// ----- rtl/wavelet_analysis_step_top.sv -----
`timescale 1ns / 1ps
// Streaming 16-tap wavelet analysis of one line.
// samples: one signed Q16.16 sample per transfer, in line order.
// results: one smooth/detail pair per transfer with its output index,
//   a clip flag and a flag on the last pair of the line.
// cfg_we/cfg_index/cfg_data: index 0 is the half length n, index 1 the
//   shrink mode; any write restarts the line. Write only while idle.
// Throughput: one sample per cycle while the queue has room. In periodic mode
//   the last sample of a line is followed by eight wrapped pairs, one per cycle
//   while the queue has room, during which samples are not taken; such a line
//   is 2n samples long. In shrink mode a line is 2n + 14 samples long.
// A pair passes from the queue through the product, partial-sum, final-sum
//   and output registers; wrapped pairs follow the last sample once the
//   front has entered its wrap state and the queue has room.
// A two-entry queue sits between the classifying front and the
//   multiply/add pipeline; the front keeps taking samples while the
//   receiver stalls until that queue fills.
// Reset clears the sample window, the position in the line and the
//   registers (n = 16, periodic).
module wavelet_analysis_step_top #(
  parameter int MAX_HALF    = 1024,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [was_pkg::CFG_BITS-1:0]  cfg_data,
  was_in_if.sink                        samples,
  was_out_if.source                     results
);

  localparam int DW = was_pkg::TAPS * SAMPLE_BITS;
  localparam int QW = $bits(was_pkg::job_ctl_t) + DW;

  logic              push;
  logic              q_ready;
  logic              q_valid;
  logic              q_pop;
  logic [DW-1:0]     job_data;
  logic [QW-1:0]     q_out;
  was_pkg::job_ctl_t job_ctl;
  was_pkg::job_ctl_t q_ctl;

  was_front #(
    .MAX_HALF   (MAX_HALF),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .samples  (samples),
    .q_ready  (q_ready),
    .push     (push),
    .job_data (job_data),
    .job_ctl  (job_ctl)
  );

  was_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({job_ctl, job_data}),
    .push_ready(q_ready),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_out)
  );

  assign q_ctl = q_out[QW-1:DW];

  was_back #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(q_valid),
    .q_data (q_out[DW-1:0]),
    .q_ctl  (q_ctl),
    .q_pop  (q_pop),
    .results(results)
  );

endmodule

// ----- rtl/was_checker.sv -----
`timescale 1ns / 1ps
`include "wavelet_analysis_step_top_macros.svh"
module was_checker #(
  parameter int SAMPLE_BITS = 32
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [was_pkg::INDEX_BITS-1:0] coeff_index,
  input logic signed [SAMPLE_BITS-1:0] smooth,
  input logic signed [SAMPLE_BITS-1:0] detail,
  input logic                          saturated,
  input logic                          last_of_line
);

  localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Hold a stalled result
  `WAS_ASSERT(a_hold, clk, rst, res_valid && !res_ready |=> res_valid && $stable(coeff_index) && $stable(smooth) && $stable(detail) && $stable(saturated) && $stable(last_of_line), "result changed while stalled")

  // Drop results at reset
  `WAS_ASSERT_ALWAYS(a_reset, clk, rst |=> !res_valid, "result valid right after reset")

  // A clip flag comes with a clipped value
  `WAS_ASSERT(a_clip, clk, rst, res_valid && saturated |-> smooth == SMAX || smooth == SMIN || detail == SMAX || detail == SMIN, "clip flag without a limit value")

endmodule

bind wavelet_analysis_step_top was_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (results.valid),
  .res_ready   (results.ready),
  .coeff_index (results.coeff_index),
  .smooth      (results.smooth),
  .detail      (results.detail),
  .saturated   (results.saturated),
  .last_of_line(results.last_of_line)
);
